FILE: rtl/core/rmde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmde_pkg: shared types, codes and move tables
// Function codes, control/status structs and the per-move read and term plans
// used by the route move delta evaluator.
// ----------------------------------------------------------------------------
package rmde_pkg;

  localparam int NODE_COUNT_DEF  = 64;
  localparam int ROUTE_DEPTH_DEF = 64;
  localparam int DIST_BITS_DEF   = 24;

  localparam int NODE_W    = 6;
  localparam int POS_W     = 6;
  localparam int LEN_W     = 7;
  localparam int DVAL_W    = 24;
  localparam int DELTA_W   = 28;
  localparam int MAX_TERMS = 12;

  localparam longint DELTA_MAX = 134217727;
  localparam longint DELTA_MIN = -134217728;

  localparam logic [1:0] SIDE_A = 2'd0;
  localparam logic [1:0] SIDE_B = 2'd1;

  typedef enum logic [3:0] {
    FN_LOAD_DIST = 4'd0,
    FN_LOAD_A    = 4'd1,
    FN_LOAD_B    = 4'd2,
    FN_INSERT    = 4'd3,
    FN_TWO_OPT   = 4'd4,
    FN_OR_OPT    = 4'd5,
    FN_EXCHANGE  = 4'd6,
    FN_SWAP11    = 4'd7,
    FN_SWAP22    = 4'd8,
    FN_SHIFT10   = 4'd9,
    FN_SHIFT20   = 4'd10,
    FN_SWAP21    = 4'd11,
    FN_LOCKER    = 4'd12,
    FN_DESTROY   = 4'd13,
    FN_SPLIT     = 4'd14
  } func_e;

  typedef enum logic [0:0] {
    REG_ROUTE_A_LEN = 1'b0,
    REG_ROUTE_B_LEN = 1'b1
  } cfg_reg_e;

  // node slots: prev/first/second/next around pos_a, then around pos_b
  typedef enum logic [3:0] {
    SRC_AP = 4'd0,
    SRC_A1 = 4'd1,
    SRC_A2 = 4'd2,
    SRC_AN = 4'd3,
    SRC_BP = 4'd4,
    SRC_B1 = 4'd5,
    SRC_B2 = 4'd6,
    SRC_BN = 4'd7,
    SRC_NF = 4'd8,
    SRC_D0 = 4'd9,
    SRC_D1 = 4'd10
  } src_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_TERM,
    ST_DRAIN,
    ST_FIN
  } st_e;

  typedef struct packed {
    logic              en;
    logic              route_b;
    logic signed [8:0] pos;
  } rd_desc_t;

  typedef struct packed {
    logic en;
    logic sub;
    src_e row;
    src_e col;
  } term_desc_t;

  typedef struct packed {
    logic       accept;      // any request taken this cycle
    logic       latch;       // evaluate request taken, capture operands
    logic       rd_issue;
    logic [2:0] rd_idx;
    logic       term_issue;
    logic [3:0] term_idx;
    logic       finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [3:0] n_terms;
  } dp_status_t;

  function automatic term_desc_t tm(logic on, logic sub, src_e r, src_e c);
    term_desc_t t;
    t.en  = on;
    t.sub = sub;
    t.row = r;
    t.col = c;
    return t;
  endfunction

  // Route position for node slot idx; en marks slots the move really reads.
  function automatic rd_desc_t rd_desc(func_e f, logic [1:0] side, logic [5:0] pa,
                                       logic [5:0] pb, logic [5:0] k, logic adj,
                                       logic [2:0] idx);
    logic signed [8:0] sa;
    logic signed [8:0] sb;
    logic signed [8:0] sc;
    logic signed [8:0] sk;
    logic signed [8:0] p [8];
    logic [7:0]        en_m;
    logic [7:0]        b_m;
    rd_desc_t          d;
    sa = 9'(pa);
    sb = 9'(pb);
    sk = 9'(k);
    sc = (side == SIDE_A) ? sb : sa;
    p[0] = sa - 9'sd1;
    p[1] = sa;
    p[2] = sa + 9'sd1;
    p[3] = sa + 9'sd1;
    p[4] = sb - 9'sd1;
    p[5] = sb;
    p[6] = sb + 9'sd1;
    p[7] = sb + 9'sd1;
    en_m = 8'h00;
    b_m  = 8'h00;
    case (f)
      FN_INSERT: begin
        p[0] = sa;
        en_m = 8'b0000_1001;
      end
      FN_TWO_OPT: begin
        p[6] = sb - 9'sd1;
        en_m = 8'b0110_0110;
      end
      FN_OR_OPT: begin
        p[2] = sa + sk - 9'sd1;
        p[3] = sa + sk;
        en_m = 8'b0011_1111;
      end
      FN_EXCHANGE: begin
        en_m = adj ? 8'b1010_0011 : 8'b1011_1011;
      end
      FN_SWAP11: begin
        en_m = 8'b1011_1011;
        b_m  = 8'hF0;
      end
      FN_SWAP22: begin
        p[3] = sa + 9'sd2;
        p[7] = sb + 9'sd2;
        en_m = 8'hFF;
        b_m  = 8'hF0;
      end
      FN_SHIFT10: begin
        en_m = 8'b1010_1011;
        b_m  = 8'hF0;
      end
      FN_SHIFT20: begin
        p[3] = sa + 9'sd2;
        en_m = 8'b1010_1111;
        b_m  = 8'hF0;
      end
      FN_SWAP21: begin
        p[3] = sa + 9'sd2;
        en_m = 8'b1011_1111;
        b_m  = 8'hF0;
      end
      FN_LOCKER: begin
        p[0] = sc - 9'sd1;
        p[3] = sc + 9'sd1;
        en_m = adj ? 8'h00 : 8'b0000_1001;
      end
      FN_DESTROY: begin
        en_m = 8'b0000_1011;
      end
      FN_SPLIT: begin
        p[2] = sb;
        p[3] = sb + 9'sd1;
        en_m = 8'b0000_1111;
      end
      default: begin
        en_m = 8'h00;
      end
    endcase
    d.en      = en_m[idx];
    d.route_b = b_m[idx];
    d.pos     = p[idx];
    return d;
  endfunction

  // Number of term steps a move walks through (disabled sides included).
  function automatic logic [3:0] term_count(func_e f, logic adj);
    logic [3:0] n;
    case (f)
      FN_INSERT:   n = 4'd3;
      FN_TWO_OPT:  n = 4'd4;
      FN_OR_OPT:   n = 4'd6;
      FN_EXCHANGE: n = adj ? 4'd4 : 4'd8;
      FN_SWAP11:   n = 4'd8;
      FN_SWAP22:   n = 4'd12;
      FN_SHIFT10:  n = 4'd6;
      FN_SHIFT20:  n = 4'd8;
      FN_SWAP21:   n = 4'd10;
      FN_LOCKER:   n = adj ? 4'd0 : 4'd3;
      FN_DESTROY:  n = 4'd3;
      FN_SPLIT:    n = 4'd5;
      default:     n = 4'd0;
    endcase
    return n;
  endfunction

  // One signed distance lookup of the move; route a part first, then route b.
  function automatic term_desc_t term_desc(func_e f, logic [1:0] side, logic adj,
                                           logic [3:0] idx);
    term_desc_t t [MAX_TERMS];
    term_desc_t d;
    logic       da;
    logic       db;
    da = (side != SIDE_B);
    db = (side != SIDE_A);
    for (int i = 0; i < MAX_TERMS; i++) begin
      t[i] = '0;
    end
    case (f)
      FN_INSERT: begin
        t[0] = tm(1'b1, 1'b0, SRC_AP, SRC_NF);
        t[1] = tm(1'b1, 1'b0, SRC_NF, SRC_AN);
        t[2] = tm(1'b1, 1'b1, SRC_AP, SRC_AN);
      end
      FN_TWO_OPT: begin
        t[0] = tm(1'b1, 1'b0, SRC_A1, SRC_B2);
        t[1] = tm(1'b1, 1'b0, SRC_A2, SRC_B1);
        t[2] = tm(1'b1, 1'b1, SRC_A1, SRC_A2);
        t[3] = tm(1'b1, 1'b1, SRC_B2, SRC_B1);
      end
      FN_OR_OPT: begin
        t[0] = tm(1'b1, 1'b0, SRC_AP, SRC_AN);
        t[1] = tm(1'b1, 1'b1, SRC_AP, SRC_A1);
        t[2] = tm(1'b1, 1'b1, SRC_A2, SRC_AN);
        t[3] = tm(1'b1, 1'b0, SRC_BP, SRC_A1);
        t[4] = tm(1'b1, 1'b0, SRC_A2, SRC_B1);
        t[5] = tm(1'b1, 1'b1, SRC_BP, SRC_B1);
      end
      FN_EXCHANGE: begin
        if (adj) begin
          t[0] = tm(1'b1, 1'b0, SRC_AP, SRC_B1);
          t[1] = tm(1'b1, 1'b1, SRC_AP, SRC_A1);
          t[2] = tm(1'b1, 1'b0, SRC_A1, SRC_BN);
          t[3] = tm(1'b1, 1'b1, SRC_B1, SRC_BN);
        end else begin
          t[0] = tm(1'b1, 1'b0, SRC_AP, SRC_B1);
          t[1] = tm(1'b1, 1'b0, SRC_B1, SRC_AN);
          t[2] = tm(1'b1, 1'b1, SRC_AP, SRC_A1);
          t[3] = tm(1'b1, 1'b1, SRC_A1, SRC_AN);
          t[4] = tm(1'b1, 1'b0, SRC_BP, SRC_A1);
          t[5] = tm(1'b1, 1'b0, SRC_A1, SRC_BN);
          t[6] = tm(1'b1, 1'b1, SRC_BP, SRC_B1);
          t[7] = tm(1'b1, 1'b1, SRC_B1, SRC_BN);
        end
      end
      FN_SWAP11: begin
        t[0] = tm(da, 1'b0, SRC_AP, SRC_B1);
        t[1] = tm(da, 1'b0, SRC_B1, SRC_AN);
        t[2] = tm(da, 1'b1, SRC_AP, SRC_A1);
        t[3] = tm(da, 1'b1, SRC_A1, SRC_AN);
        t[4] = tm(db, 1'b0, SRC_BP, SRC_A1);
        t[5] = tm(db, 1'b0, SRC_A1, SRC_BN);
        t[6] = tm(db, 1'b1, SRC_BP, SRC_B1);
        t[7] = tm(db, 1'b1, SRC_B1, SRC_BN);
      end
      FN_SWAP22: begin
        t[0]  = tm(da, 1'b0, SRC_AP, SRC_B1);
        t[1]  = tm(da, 1'b0, SRC_B1, SRC_B2);
        t[2]  = tm(da, 1'b0, SRC_B2, SRC_AN);
        t[3]  = tm(da, 1'b1, SRC_AP, SRC_A1);
        t[4]  = tm(da, 1'b1, SRC_A1, SRC_A2);
        t[5]  = tm(da, 1'b1, SRC_A2, SRC_AN);
        t[6]  = tm(db, 1'b0, SRC_BP, SRC_A1);
        t[7]  = tm(db, 1'b0, SRC_A1, SRC_A2);
        t[8]  = tm(db, 1'b0, SRC_A2, SRC_BN);
        t[9]  = tm(db, 1'b1, SRC_BP, SRC_B1);
        t[10] = tm(db, 1'b1, SRC_B1, SRC_B2);
        t[11] = tm(db, 1'b1, SRC_B2, SRC_BN);
      end
      FN_SHIFT10: begin
        t[0] = tm(da, 1'b0, SRC_AP, SRC_AN);
        t[1] = tm(da, 1'b1, SRC_AP, SRC_A1);
        t[2] = tm(da, 1'b1, SRC_A1, SRC_AN);
        t[3] = tm(db, 1'b0, SRC_B1, SRC_A1);
        t[4] = tm(db, 1'b0, SRC_A1, SRC_BN);
        t[5] = tm(db, 1'b1, SRC_B1, SRC_BN);
      end
      FN_SHIFT20: begin
        t[0] = tm(da, 1'b0, SRC_AP, SRC_AN);
        t[1] = tm(da, 1'b1, SRC_AP, SRC_A1);
        t[2] = tm(da, 1'b1, SRC_A1, SRC_A2);
        t[3] = tm(da, 1'b1, SRC_A2, SRC_AN);
        t[4] = tm(db, 1'b0, SRC_B1, SRC_A1);
        t[5] = tm(db, 1'b0, SRC_A1, SRC_A2);
        t[6] = tm(db, 1'b0, SRC_A2, SRC_BN);
        t[7] = tm(db, 1'b1, SRC_B1, SRC_BN);
      end
      FN_SWAP21: begin
        t[0] = tm(da, 1'b0, SRC_AP, SRC_B1);
        t[1] = tm(da, 1'b0, SRC_B1, SRC_AN);
        t[2] = tm(da, 1'b1, SRC_AP, SRC_A1);
        t[3] = tm(da, 1'b1, SRC_A1, SRC_A2);
        t[4] = tm(da, 1'b1, SRC_A2, SRC_AN);
        t[5] = tm(db, 1'b0, SRC_BP, SRC_A1);
        t[6] = tm(db, 1'b0, SRC_A1, SRC_A2);
        t[7] = tm(db, 1'b0, SRC_A2, SRC_BN);
        t[8] = tm(db, 1'b1, SRC_BP, SRC_B1);
        t[9] = tm(db, 1'b1, SRC_B1, SRC_BN);
      end
      FN_LOCKER: begin
        t[0] = tm(!adj, 1'b0, SRC_AP, SRC_AN);
        t[1] = tm(!adj, 1'b1, SRC_AP, SRC_NF);
        t[2] = tm(!adj, 1'b1, SRC_NF, SRC_AN);
      end
      FN_DESTROY: begin
        t[0] = tm(1'b1, 1'b0, SRC_AP, SRC_AN);
        t[1] = tm(1'b1, 1'b1, SRC_AP, SRC_A1);
        t[2] = tm(1'b1, 1'b1, SRC_A1, SRC_AN);
      end
      FN_SPLIT: begin
        t[0] = tm(da, 1'b0, SRC_AP, SRC_AN);
        t[1] = tm(da, 1'b1, SRC_AP, SRC_A1);
        t[2] = tm(da, 1'b1, SRC_A2, SRC_AN);
        t[3] = tm(db, 1'b0, SRC_D0, SRC_A1);
        t[4] = tm(db, 1'b0, SRC_A2, SRC_D1);
      end
      default: begin
        t[0] = '0;
      end
    endcase
    if (idx < 4'(MAX_TERMS)) begin
      d = t[idx];
    end else begin
      d = '0;
    end
    return d;
  endfunction

endpackage

FILE: rtl/core/rmde_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmde_ctrl: move evaluation sequencer
// Accepts requests and steps the datapath through node reads, distance
// lookups and the final result write.
// ----------------------------------------------------------------------------
module rmde_ctrl import rmde_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [3:0] func,
  input  dp_status_t status,
  output logic       busy,
  output ctrl_cmd_t  cmd
);

  st_e        state;
  st_e        state_next;
  logic [3:0] cnt;
  logic [3:0] cnt_next;
  logic       is_eval;

  assign is_eval = func_e'(func) inside {[FN_INSERT:FN_SPLIT]};
  assign busy    = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cmd            = '0;
    cmd.rd_idx     = cnt[2:0];
    cmd.term_idx   = cnt;
    case (state)
      ST_IDLE: begin
        cmd.accept = start;
        cmd.latch  = start && is_eval;
        if (start && is_eval) begin
          state_next = ST_READ;
          cnt_next   = '0;
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        cnt_next     = cnt + 4'd1;
        if (cnt == 4'd7) begin
          state_next = ST_WAIT;
          cnt_next   = '0;
        end
      end
      ST_WAIT: begin
        // last node lands in its slot at the end of this cycle
        if (status.n_terms == 4'd0) begin
          state_next = ST_FIN;
        end else begin
          state_next = ST_TERM;
        end
      end
      ST_TERM: begin
        cmd.term_issue = 1'b1;
        cnt_next       = cnt + 4'd1;
        if (cnt == status.n_terms - 4'd1) begin
          state_next = ST_DRAIN;
          cnt_next   = '0;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_fin_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (state == ST_IDLE))
    else $error("sequencer did not return to idle after finish");

  a_term_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.term_issue |-> (cnt < status.n_terms))
    else $error("term index beyond move plan");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy raised without a request");
`endif

endmodule

FILE: rtl/core/rmde_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmde_dpath: tables, node slots and delta accumulator
// Holds the distance table and both route node lists, reads one node and one
// distance per cycle and sums the signed lookups into a saturated delta.
// ----------------------------------------------------------------------------
module rmde_dpath import rmde_pkg::*; #(
  parameter int NODE_COUNT  = NODE_COUNT_DEF,
  parameter int ROUTE_DEPTH = ROUTE_DEPTH_DEF,
  parameter int DIST_BITS   = DIST_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [LEN_W-1:0]          cfg_data,
  input  logic [3:0]                func,
  input  logic [NODE_W-1:0]         node_from,
  input  logic [NODE_W-1:0]         node_to,
  input  logic [DVAL_W-1:0]         dist_value,
  input  logic [POS_W-1:0]          pos_a,
  input  logic [POS_W-1:0]          pos_b,
  input  logic [POS_W-1:0]          seg_len,
  input  logic [1:0]                side,
  input  ctrl_cmd_t                 cmd,
  output dp_status_t                status,
  output logic signed [DELTA_W-1:0] delta,
  output logic                      range_error,
  output logic                      done
);

  localparam int AW    = $clog2(ROUTE_DEPTH);
  localparam int DEPTH = NODE_COUNT * NODE_COUNT;
  localparam int DAW   = $clog2(DEPTH);
  localparam int ACC_W = (DIST_BITS + 6 > 29) ? DIST_BITS + 6 : 29;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(DELTA_MAX);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(DELTA_MIN);

  // configuration
  logic [LEN_W-1:0] len_a;
  logic [LEN_W-1:0] len_b;

  // latched operands
  func_e            func_q;
  logic [1:0]       side_q;
  logic [POS_W-1:0] pa_q;
  logic [POS_W-1:0] pb_q;
  logic [POS_W-1:0] k_q;
  logic [NODE_W-1:0] nf_q;
  logic             adj;

  // stores
  logic [DIST_BITS-1:0] dist_mem [DEPTH];
  logic [NODE_W-1:0]    ra_mem [ROUTE_DEPTH];
  logic [NODE_W-1:0]    rb_mem [ROUTE_DEPTH];
  logic [DIST_BITS-1:0] dist_q;
  logic [NODE_W-1:0]    ra_q;
  logic [NODE_W-1:0]    rb_q;

  // node read step
  rd_desc_t         rd;
  logic [7:0]       pos_u;
  logic             pos_ok;
  logic [AW-1:0]    r_addr;
  logic             rd_v_q;
  logic [2:0]       rd_idx_q;
  logic             rd_b_q;
  logic [7:0][NODE_W-1:0] slot;

  // route load
  logic             wr_ok;
  logic [AW-1:0]    wr_addr;

  // distance lookup step
  term_desc_t       td;
  logic [NODE_W-1:0] row;
  logic [NODE_W-1:0] col;
  logic             rc_ok;
  logic [DAW-1:0]   d_raddr;
  logic             dw_ok;
  logic [DAW-1:0]   d_waddr;
  logic             tv_q;
  logic             tsub_q;

  // accumulation
  logic [ACC_W-1:0]        acc;
  logic [ACC_W-1:0]        term_val;
  logic                    err;
  logic signed [ACC_W-1:0] acc_s;
  logic signed [ACC_W-1:0] sat;

  function automatic logic [NODE_W-1:0] pick(src_e s, logic [7:0][NODE_W-1:0] sl,
                                             logic [NODE_W-1:0] nf);
    logic [NODE_W-1:0] v;
    case (s)
      SRC_NF:  v = nf;
      SRC_D0:  v = NODE_W'(0);
      SRC_D1:  v = NODE_W'(1);
      default: v = sl[s[2:0]];
    endcase
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      len_a <= '0;
      len_b <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        REG_ROUTE_A_LEN: len_a <= cfg_data;
        REG_ROUTE_B_LEN: len_b <= cfg_data;
        default:         len_a <= len_a;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_q <= func_e'(func);
      side_q <= side;
      pa_q   <= pos_a;
      pb_q   <= pos_b;
      k_q    <= seg_len;
      nf_q   <= node_from;
    end
  end

  assign adj            = ({1'b0, pb_q} == ({1'b0, pa_q} + 7'd1));
  assign status.n_terms = term_count(func_q, adj);

  // ---- route node reads ----
  assign rd     = rd_desc(func_q, side_q, pa_q, pb_q, k_q, adj, cmd.rd_idx);
  assign pos_u  = rd.pos[7:0];
  assign pos_ok = !rd.pos[8] && (32'(pos_u) < ROUTE_DEPTH) &&
                  ({1'b0, pos_u} < (rd.route_b ? {2'b0, len_b} : {2'b0, len_a}));
  assign r_addr = AW'(pos_u);

  assign wr_ok   = 32'(pos_a) < ROUTE_DEPTH;
  assign wr_addr = AW'(pos_a);

  always_ff @(posedge clk) begin
    if (cmd.accept && wr_ok && (func_e'(func) == FN_LOAD_A)) begin
      ra_mem[wr_addr] <= node_from;
    end
    ra_q <= ra_mem[r_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && wr_ok && (func_e'(func) == FN_LOAD_B)) begin
      rb_mem[wr_addr] <= node_from;
    end
    rb_q <= rb_mem[r_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v_q <= 1'b0;
    end else begin
      rd_v_q <= cmd.rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_q <= cmd.rd_idx;
    rd_b_q   <= rd.route_b;
    if (rd_v_q) begin
      slot[rd_idx_q] <= rd_b_q ? rb_q : ra_q;
    end
  end

  // ---- distance lookups ----
  assign td    = term_desc(func_q, side_q, adj, cmd.term_idx);
  assign row   = pick(td.row, slot, nf_q);
  assign col   = pick(td.col, slot, nf_q);
  assign rc_ok = (32'(row) < NODE_COUNT) && (32'(col) < NODE_COUNT);
  assign d_raddr = DAW'(row) * DAW'(NODE_COUNT) + DAW'(col);

  assign dw_ok   = (32'(node_from) < NODE_COUNT) && (32'(node_to) < NODE_COUNT);
  assign d_waddr = DAW'(node_from) * DAW'(NODE_COUNT) + DAW'(node_to);

  always_ff @(posedge clk) begin
    if (cmd.accept && dw_ok && (func_e'(func) == FN_LOAD_DIST)) begin
      dist_mem[d_waddr] <= DIST_BITS'(dist_value);
    end
    dist_q <= dist_mem[d_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tv_q <= 1'b0;
    end else begin
      tv_q <= cmd.term_issue && td.en && rc_ok;
    end
  end

  always_ff @(posedge clk) begin
    tsub_q <= td.sub;
  end

  // ---- accumulate ----
  assign term_val = ACC_W'(dist_q);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      acc <= '0;
    end else if (tv_q) begin
      acc <= tsub_q ? (acc - term_val) : (acc + term_val);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err <= 1'b0;
    end else if (cmd.latch) begin
      err <= 1'b0;
    end else if (cmd.rd_issue && rd.en && !pos_ok) begin
      err <= 1'b1;
    end
  end

  always_comb begin
    acc_s = $signed(acc);
    if (acc_s > SAT_HI) begin
      sat = SAT_HI;
    end else if (acc_s < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = acc_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      delta       <= err ? '0 : sat[DELTA_W-1:0];
      range_error <= err;
    end
  end

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done |-> (!range_error || (delta == '0)))
    else $error("range error reported with nonzero delta");
`endif

endmodule

FILE: rtl/core/route_move_delta_evaluator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// route_move_delta_evaluator: local-search move cost engine
// Distance table and two route lists with a sequenced evaluator that returns
// the signed route-length change of one vehicle-routing move.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Loads (distance
// entry, route a node, route b node) and the unused function code finish as
// they are taken, raise no busy and return nothing. A move request returns
// exactly one result: done is high for one cycle with delta and range_error
// valid; the receiver cannot stall, so it must capture the result on that
// cycle. A move keeps busy high until its result is registered. T, the
// length of the move's lookup plan, runs from 3 for insertion or destruction
// up to 12 for swap 2-2 and is 0 for an adjacent locker reduce. The steps
// come from one route read port and one distance-table read port, each used
// once per cycle: eight node reads, then one distance lookup per term. A new
// request may be started in the cycle that done is shown. The tables come up
// undefined after reset and need no clearing pass; length registers reset to
// zero. Write the length registers only while busy is low.
// ----------------------------------------------------------------------------
//
// Flow of one move:
//   READ   one route node position per cycle (slots prev/first/second/next
//          around pos_a and pos_b); each used position is range checked
//          against its route's length, a miss flags range_error.
//   WAIT   lets the last node settle into its slot.
//   TERM   one signed distance lookup per term of the plan; terms of a side
//          that is not selected are walked but not summed.
//   DRAIN  last lookup is added.
//   FIN    saturate to 28 bits (zero on range error) and register the result.
//
// Node ids at or beyond NODE_COUNT look up as distance zero; loads to
// out-of-range rows, columns or positions are dropped.
module route_move_delta_evaluator import rmde_pkg::*; #(
  parameter int NODE_COUNT  = NODE_COUNT_DEF,
  parameter int ROUTE_DEPTH = ROUTE_DEPTH_DEF,
  parameter int DIST_BITS   = DIST_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration write port
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [LEN_W-1:0]          cfg_data,
  // request
  input  logic                      start,
  output logic                      busy,
  input  logic [3:0]                func,
  input  logic [NODE_W-1:0]         node_from,
  input  logic [NODE_W-1:0]         node_to,
  input  logic [DVAL_W-1:0]         dist_value,
  input  logic [POS_W-1:0]          pos_a,
  input  logic [POS_W-1:0]          pos_b,
  input  logic [POS_W-1:0]          seg_len,
  input  logic [1:0]                side,
  // result
  output logic                      done,
  output logic signed [DELTA_W-1:0] delta,
  output logic                      range_error
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer: request acceptance and step counting
  rmde_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .func   (func),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  // datapath: stores, node slots, lookup pipeline and accumulator
  rmde_dpath #(
    .NODE_COUNT  (NODE_COUNT),
    .ROUTE_DEPTH (ROUTE_DEPTH),
    .DIST_BITS   (DIST_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .func        (func),
    .node_from   (node_from),
    .node_to     (node_to),
    .dist_value  (dist_value),
    .pos_a       (pos_a),
    .pos_b       (pos_b),
    .seg_len     (seg_len),
    .side        (side),
    .cmd         (cmd),
    .status      (status),
    .delta       (delta),
    .range_error (range_error),
    .done        (done)
  );

endmodule
